// ----- hw/rtl/sprite_frame_animator_macros.svh -----
// ----------------------------------------------------------------------------
// Sprite frame animator assertion macros
// Shorthand for clocked implication checks disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_ANIMATOR_MACROS_SVH
`define SPRITE_FRAME_ANIMATOR_MACROS_SVH

// Same-cycle implication
`define SFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite frame animator package
// Shared widths, register indexes and the divider request/response types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

    localparam int DIV_W  = 24;
    localparam int STEP_W = 5;

    // quotient bits produced per division kind
    localparam logic [STEP_W-1:0] STEPS_TIME = 5'd24;
    localparam logic [STEP_W-1:0] STEPS_IDX  = 5'd16;
    localparam logic [STEP_W-1:0] STEPS_DIM  = 5'd13;

    localparam logic [12:0] EDGE_MAX  = 13'd4096;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic [2:0] CFG_FRAME_DELAY   = 3'd0;
    localparam logic [2:0] CFG_START_FRAME   = 3'd1;
    localparam logic [2:0] CFG_END_FRAME     = 3'd2;
    localparam logic [2:0] CFG_SHEET_COLUMNS = 3'd3;
    localparam logic [2:0] CFG_SHEET_ROWS    = 3'd4;
    localparam logic [2:0] CFG_SHEET_WIDTH   = 3'd5;
    localparam logic [2:0] CFG_SHEET_HEIGHT  = 3'd6;
    localparam logic [2:0] CFG_LOOP_FOREVER  = 3'd7;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;   // left-aligned to the top bit
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- hw/rtl/sfa_div.sv -----
// ----------------------------------------------------------------------------
// Sprite frame animator divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfa_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sfa_pkg::t_div_req i_req,
    output sfa_pkg::t_div_rsp    o_rsp
);

    logic                       r_busy;
    logic                       r_done;
    logic [sfa_pkg::STEP_W-1:0] r_cnt;
    logic [sfa_pkg::DIV_W-1:0]  r_rem;
    logic [sfa_pkg::DIV_W-1:0]  r_quo;
    logic [sfa_pkg::DIV_W-1:0]  r_dvs;

    logic [sfa_pkg::DIV_W:0]    w_shift;
    logic [sfa_pkg::DIV_W+1:0]  w_diff;
    logic                       w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[sfa_pkg::DIV_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
        w_ge    = !w_diff[sfa_pkg::DIV_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == sfa_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[sfa_pkg::DIV_W-1:0] : w_shift[sfa_pkg::DIV_W-1:0];
            r_quo <= {r_quo[sfa_pkg::DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

// ----- hw/rtl/sprite_frame_animator.sv -----
// ----------------------------------------------------------------------------
// Sprite frame animator
// Frame timer, frame advance and sheet rectangle for one sprite animation.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// tick      in         i_valid / o_stall   i_elapsed_time
// result    out        o_valid / i_stall   o_rect_valid .. o_done_flag
// config    in         i_cfg_we            i_cfg_index, i_cfg_wdata
//
// A tick with a timer expiry runs four divider passes (24 + 16 + 13 + 13 bits, each
// launched from a GO state and collected in a WAIT state), five sequencer steps
// and the idle state; without an expiry the time pass is skipped, and once completed
// a tick goes straight to S_OUT. o_valid rises when S_OUT loads the output register.
// o_stall is high from acceptance until the result enters the output register.
// The output register holds a result under i_stall while the next tick runs.
// Reset is synchronous; it restores register defaults and the animation state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_frame_animator_macros.svh"

module sprite_frame_animator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [23:0] i_elapsed_time,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_rect_valid,
    output logic [15:0]      o_frame_number,
    output logic [12:0]      o_rect_left,
    output logic [12:0]      o_rect_right,
    output logic [12:0]      o_rect_top,
    output logic [12:0]      o_rect_bottom,
    output logic             o_done_flag,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_SUB, S_TCHK, S_TGO, S_TWAIT, S_LIMIT, S_IGO, S_IWAIT,
        S_WGO, S_WWAIT, S_HGO, S_HWAIT, S_MUL, S_OUT
    } t_state;

    // configuration
    logic [23:0] r_frame_delay;
    logic [12:0] r_start_frame;
    logic [12:0] r_end_frame;
    logic [6:0]  r_sheet_columns;
    logic [6:0]  r_sheet_rows;
    logic [12:0] r_sheet_width;
    logic [12:0] r_sheet_height;
    logic        r_loop_forever;

    // animation state and work registers
    t_state        r_state;
    logic signed [25:0] r_tr;
    logic [15:0]   r_counter;
    logic          r_finished;
    logic [23:0]   r_elapsed;
    logic [6:0]    r_col0;
    logic [15:0]   r_row0;
    logic [12:0]   r_cw;
    logic [12:0]   r_rh;
    logic [19:0]   r_left_p;
    logic [28:0]   r_top_p;

    // output register
    logic          r_o_valid;
    logic          r_rect_valid;
    logic [15:0]   r_frame_number;
    logic [12:0]   r_rect_left;
    logic [12:0]   r_rect_right;
    logic [12:0]   r_rect_top;
    logic [12:0]   r_rect_bottom;
    logic          r_done_flag;

    sfa_pkg::t_div_req w_req;
    sfa_pkg::t_div_rsp w_rsp;

    logic [23:0] w_delay;
    logic [6:0]  w_cols;
    logic [6:0]  w_rows;
    logic [15:0] w_idx;
    logic [23:0] w_overrun;
    logic [24:0] w_sum;
    logic [15:0] w_sat;
    logic [20:0] w_right;
    logic [29:0] w_bottom;
    logic        w_accept;
    logic        w_out_free;

    function automatic logic [12:0] f_clamp(input logic [29:0] v);
        return (v > 30'(sfa_pkg::EDGE_MAX)) ? sfa_pkg::EDGE_MAX : v[12:0];
    endfunction

    always_comb begin
        w_delay    = (r_frame_delay == '0) ? 24'd1 : r_frame_delay;
        w_cols     = (r_sheet_columns == '0) ? 7'd1 : r_sheet_columns;
        w_rows     = (r_sheet_rows == '0) ? 7'd1 : r_sheet_rows;
        w_idx      = (r_counter == '0) ? 16'd0 : r_counter - 16'd1;
        w_overrun  = 24'(-r_tr);
        w_sum      = {9'd0, r_counter} + {1'b0, w_rsp.quotient} + 25'd1;
        w_sat      = (w_sum > 25'(sfa_pkg::COUNT_MAX)) ? sfa_pkg::COUNT_MAX : w_sum[15:0];
        w_right    = {1'b0, r_left_p} + {8'd0, r_cw};
        w_bottom   = {1'b0, r_top_p} + {17'd0, r_rh};
        w_accept   = i_valid && (r_state == S_IDLE);
        w_out_free = !r_o_valid || !i_stall;
    end

    // divider requests, left-aligned dividends
    always_comb begin
        w_req = '0;
        case (r_state)
            S_TGO: begin
                w_req.start    = 1'b1;
                w_req.dividend = w_overrun;
                w_req.divisor  = w_delay;
                w_req.steps    = sfa_pkg::STEPS_TIME;
            end
            S_IGO: begin
                w_req.start    = 1'b1;
                w_req.dividend = {w_idx, 8'd0};
                w_req.divisor  = {17'd0, w_cols};
                w_req.steps    = sfa_pkg::STEPS_IDX;
            end
            S_WGO: begin
                w_req.start    = 1'b1;
                w_req.dividend = {r_sheet_width, 11'd0};
                w_req.divisor  = {17'd0, w_cols};
                w_req.steps    = sfa_pkg::STEPS_DIM;
            end
            S_HGO: begin
                w_req.start    = 1'b1;
                w_req.dividend = {r_sheet_height, 11'd0};
                w_req.divisor  = {17'd0, w_rows};
                w_req.steps    = sfa_pkg::STEPS_DIM;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    sfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_delay   <= 24'd6554;
            r_start_frame   <= 13'd1;
            r_end_frame     <= 13'd1;
            r_sheet_columns <= 7'd1;
            r_sheet_rows    <= 7'd1;
            r_sheet_width   <= 13'd64;
            r_sheet_height  <= 13'd64;
            r_loop_forever  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfa_pkg::CFG_FRAME_DELAY:   r_frame_delay   <= i_cfg_wdata;
                sfa_pkg::CFG_START_FRAME:   r_start_frame   <= i_cfg_wdata[12:0];
                sfa_pkg::CFG_END_FRAME:     r_end_frame     <= i_cfg_wdata[12:0];
                sfa_pkg::CFG_SHEET_COLUMNS: r_sheet_columns <= i_cfg_wdata[6:0];
                sfa_pkg::CFG_SHEET_ROWS:    r_sheet_rows    <= i_cfg_wdata[6:0];
                sfa_pkg::CFG_SHEET_WIDTH:   r_sheet_width   <= i_cfg_wdata[12:0];
                sfa_pkg::CFG_SHEET_HEIGHT:  r_sheet_height  <= i_cfg_wdata[12:0];
                sfa_pkg::CFG_LOOP_FOREVER:  r_loop_forever  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tr       <= '0;
            r_counter  <= 16'd1;
            r_finished <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_o_valid && !i_stall && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_elapsed <= i_elapsed_time;
                        r_state   <= r_finished ? S_OUT : S_SUB;
                    end
                end
                S_SUB: begin
                    r_tr    <= r_tr - $signed({2'b00, r_elapsed});
                    r_state <= S_TCHK;
                end
                S_TCHK: begin
                    r_state <= (r_tr[25] || r_tr == '0) ? S_TGO : S_LIMIT;
                end
                S_TGO: begin
                    r_state <= S_TWAIT;
                end
                S_TWAIT: begin
                    if (w_rsp.done) begin
                        // refill: remaining time becomes delay minus the overrun remainder
                        r_counter <= w_sat;
                        r_tr      <= $signed({2'b00, w_delay} - {2'b00, w_rsp.remainder});
                        r_state   <= S_LIMIT;
                    end
                end
                S_LIMIT: begin
                    if (r_counter > {3'd0, r_end_frame}) begin
                        if (r_loop_forever) begin
                            r_counter <= {3'd0, r_start_frame};
                            r_state   <= S_IGO;
                        end else begin
                            r_finished <= 1'b1;
                            r_state    <= S_OUT;
                        end
                    end else begin
                        r_state <= S_IGO;
                    end
                end
                S_IGO: begin
                    r_state <= S_IWAIT;
                end
                S_IWAIT: begin
                    if (w_rsp.done) begin
                        r_col0  <= w_rsp.remainder[6:0];
                        r_row0  <= w_rsp.quotient[15:0];
                        r_state <= S_WGO;
                    end
                end
                S_WGO: begin
                    r_state <= S_WWAIT;
                end
                S_WWAIT: begin
                    if (w_rsp.done) begin
                        r_cw    <= w_rsp.quotient[12:0];
                        r_state <= S_HGO;
                    end
                end
                S_HGO: begin
                    r_state <= S_HWAIT;
                end
                S_HWAIT: begin
                    if (w_rsp.done) begin
                        r_rh    <= w_rsp.quotient[12:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_left_p <= 20'(r_col0 * r_cw);
                    r_top_p  <= 29'(r_row0 * r_rh);
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_o_valid      <= 1'b1;
                        r_frame_number <= r_counter;
                        r_done_flag    <= r_finished;
                        r_rect_valid   <= !r_finished;
                        if (r_finished) begin
                            r_rect_left   <= '0;
                            r_rect_right  <= '0;
                            r_rect_top    <= '0;
                            r_rect_bottom <= '0;
                        end else begin
                            r_rect_left   <= f_clamp({10'd0, r_left_p});
                            r_rect_right  <= f_clamp({9'd0, w_right});
                            r_rect_top    <= f_clamp({1'b0, r_top_p});
                            r_rect_bottom <= f_clamp(w_bottom);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_rect_valid   = r_rect_valid;
    assign o_frame_number = r_frame_number;
    assign o_rect_left    = r_rect_left;
    assign o_rect_right   = r_rect_right;
    assign o_rect_top     = r_rect_top;
    assign o_rect_bottom  = r_rect_bottom;
    assign o_done_flag    = r_done_flag;

    `SFA_ASSERT_IMP(a_done_no_rect, i_clk, i_rst_n, o_valid && o_done_flag, !o_rect_valid, "completed animation shows a rectangle")
    `SFA_ASSERT_NXT(a_finished_sticky, i_clk, i_rst_n, r_finished, r_finished, "completion cleared without reset")
    `SFA_ASSERT_IMP(a_timer_idle, i_clk, i_rst_n, r_state == S_IDLE, !r_tr[25], "frame timer negative between ticks")

endmodule

`default_nettype wire
